// ===== sv/knn_pkg.sv =====
// Package for the k-nearest-neighbor center search block.
// Holds sizes, field widths, register indexes and function codes; no dependencies.
package knn_pkg;
    localparam int DIM_MAX     = 64;
    localparam int CENTERS_MAX = 256;
    localparam int K_MAX       = 8;
    localparam int DIM_W       = $clog2(DIM_MAX);
    localparam int CEN_W       = $clog2(CENTERS_MAX);
    localparam int K_W         = $clog2(K_MAX);
    localparam int ADDR_W      = CEN_W + DIM_W;
    localparam int DEPTH       = CENTERS_MAX * DIM_MAX;
    localparam int VAL_W       = 16;
    localparam int DIST_W      = 40;
    localparam int LBL_W       = 9;
    localparam int VLEN_W      = 7;
    localparam int CCNT_W      = 9;
    localparam int NCNT_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int SQ_W        = 34;

    localparam logic [CFG_IDX_W-1:0] REG_VLEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CCNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NCNT = 2'd2;

    localparam logic FUNC_CENTER = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};
endpackage

// ===== sv/knn_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== sv/knn_best.sv =====
// Best-list keeper: k slots of distance and label, worst-slot rescan over cycles.
// Depends on knn_pkg.
module knn_best (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_offer,
    input  logic [knn_pkg::DIST_W-1:0]  i_dist,
    input  logic [knn_pkg::LBL_W-1:0]   i_label,
    input  logic [knn_pkg::K_W:0]       i_k,
    input  logic [knn_pkg::K_W-1:0]     i_rd_slot,
    output logic [knn_pkg::DIST_W-1:0]  o_rd_dist,
    output logic [knn_pkg::LBL_W-1:0]   o_rd_label,
    output logic                        o_busy
);
    logic [knn_pkg::DIST_W-1:0] r_dist [knn_pkg::K_MAX];
    logic [knn_pkg::LBL_W-1:0]  r_lbl  [knn_pkg::K_MAX];
    logic [knn_pkg::K_W-1:0]    r_worst_slot;
    logic [knn_pkg::DIST_W-1:0] r_worst;
    logic                       r_scan;
    logic [knn_pkg::K_W:0]      r_si;
    logic [knn_pkg::DIST_W-1:0] r_mv;
    logic [knn_pkg::K_W-1:0]    r_mi;

    assign o_busy     = r_scan;
    assign o_rd_dist  = r_dist[i_rd_slot];
    assign o_rd_label = r_lbl[i_rd_slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int s = 0; s < knn_pkg::K_MAX; s++) begin
                r_dist[s] <= knn_pkg::DIST_ONES;
                r_lbl[s]  <= '0;
            end
            r_worst_slot <= '0;
            r_worst      <= knn_pkg::DIST_ONES;
            r_scan       <= 1'b0;
            r_si         <= '0;
            r_mv         <= '0;
            r_mi         <= '0;
        end else if (r_scan) begin
            // one slot per cycle; strictly larger moves the max
            if (r_si == i_k) begin
                r_worst      <= r_mv;
                r_worst_slot <= r_mi;
                r_scan       <= 1'b0;
            end else begin
                if (r_dist[r_si[knn_pkg::K_W-1:0]] > r_mv) begin
                    r_mv <= r_dist[r_si[knn_pkg::K_W-1:0]];
                    r_mi <= r_si[knn_pkg::K_W-1:0];
                end
                r_si <= r_si + 1'b1;
            end
        end else if (i_offer && i_dist < r_worst) begin
            r_dist[r_worst_slot] <= i_dist;
            r_lbl[r_worst_slot]  <= i_label;
            r_scan <= 1'b1;
            r_si   <= '0;
            r_mv   <= '0;
            r_mi   <= '0;
        end
    end
endmodule

// ===== sv/knn_center_search.sv =====
// Top level of the k-nearest-neighbor center search; instantiates knn_ram and knn_best.
// Depends on knn_pkg.
//
// Usage: pulse start with an element while busy is low. Function center
// writes one element into the center store, with no result. Function
// query writes one element into the query buffer; the element whose index is
// vector_length-1 starts a search. The search walks each of the first
// center_count centers: it streams the center's elements through the read and
// square stages, offers the distance and moves on to the next center, waiting
// for the best-list rescan when the center replaces a slot.
// Results leave one per cycle on o_valid, k of them in slot
// order, o_last_neighbor on the final one; the receiver cannot stall.
// Configuration transfers (i_cfg_valid/o_cfg_ready) are always taken.
// Reset (synchronous, active low) returns registers to 64/256/8 and idles the
// block; memory contents are undefined until written.
module knn_center_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [7:0]                        i_center_index,
    input  logic [5:0]                        i_element_index,
    input  logic signed [15:0]                i_element_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [knn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_valid,
    output logic [8:0]                        o_neighbor_label,
    output logic [39:0]                       o_neighbor_distance,
    output logic                              o_last_neighbor
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_OFF  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [knn_pkg::VLEN_W-1:0] r_vlen;
    logic [knn_pkg::CCNT_W-1:0] r_ccnt;
    logic [knn_pkg::NCNT_W-1:0] r_ncnt;
    logic [2:0]                 r_state;
    logic [knn_pkg::CEN_W:0]    r_cen;
    logic [knn_pkg::DIM_W:0]    r_el;
    logic                       r_rv;
    logic [knn_pkg::DIM_W:0]    r_rcnt;
    logic [knn_pkg::DIST_W-1:0] r_sum;
    logic [knn_pkg::SQ_W-1:0]   r_sq;
    logic                       r_sqv;
    logic [knn_pkg::K_W:0]      r_slot;
    logic [knn_pkg::DIM_W:0]    len;
    logic [knn_pkg::CEN_W:0]    nc;
    logic [knn_pkg::K_W:0]      kk;

    // clamp registers to their legal ranges
    always_comb begin
        len = (r_vlen == '0) ? (knn_pkg::DIM_W+1)'(1)
            : (r_vlen > knn_pkg::VLEN_W'(knn_pkg::DIM_MAX)) ?
              (knn_pkg::DIM_W+1)'(knn_pkg::DIM_MAX) : r_vlen[knn_pkg::DIM_W:0];
        nc  = (r_ccnt == '0) ? (knn_pkg::CEN_W+1)'(1)
            : (r_ccnt > knn_pkg::CCNT_W'(knn_pkg::CENTERS_MAX)) ?
              (knn_pkg::CEN_W+1)'(knn_pkg::CENTERS_MAX) : r_ccnt[knn_pkg::CEN_W:0];
        kk  = (r_ncnt == '0) ? (knn_pkg::K_W+1)'(1)
            : (r_ncnt > knn_pkg::NCNT_W'(knn_pkg::K_MAX)) ?
              (knn_pkg::K_W+1)'(knn_pkg::K_MAX) : r_ncnt[knn_pkg::K_W:0];
    end

    logic accept;
    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlen <= knn_pkg::VLEN_W'(64);
            r_ccnt <= knn_pkg::CCNT_W'(256);
            r_ncnt <= knn_pkg::NCNT_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                knn_pkg::REG_VLEN: r_vlen <= i_cfg_data[knn_pkg::VLEN_W-1:0];
                knn_pkg::REG_CCNT: r_ccnt <= i_cfg_data;
                knn_pkg::REG_NCNT: r_ncnt <= i_cfg_data[knn_pkg::NCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // memories: center store and query buffer, read in lockstep
    logic [knn_pkg::VAL_W-1:0]  c_rd, q_rd;
    logic [knn_pkg::ADDR_W-1:0] c_raddr;
    logic [knn_pkg::DIM_W-1:0]  q_raddr;
    logic                       rd_go;

    assign rd_go   = (r_state == ST_RUN) && (r_el < len);
    assign c_raddr = {r_cen[knn_pkg::CEN_W-1:0], r_el[knn_pkg::DIM_W-1:0]};
    assign q_raddr = r_el[knn_pkg::DIM_W-1:0];

    knn_ram #(.WIDTH(knn_pkg::VAL_W), .DEPTH(knn_pkg::DEPTH)) u_cram (
        .i_clk  (i_clk),
        .i_we   (accept && i_func == knn_pkg::FUNC_CENTER),
        .i_waddr({i_center_index, i_element_index}),
        .i_wdata(i_element_value),
        .i_raddr(c_raddr),
        .o_rdata(c_rd)
    );

    knn_ram #(.WIDTH(knn_pkg::VAL_W), .DEPTH(knn_pkg::DIM_MAX)) u_qram (
        .i_clk  (i_clk),
        .i_we   (accept && i_func == knn_pkg::FUNC_QUERY),
        .i_waddr(i_element_index),
        .i_wdata(i_element_value),
        .i_raddr(q_raddr),
        .o_rdata(q_rd)
    );

    // difference, then square in the next stage
    logic signed [knn_pkg::VAL_W:0] diff;
    logic [knn_pkg::VAL_W:0]        adiff;
    logic [knn_pkg::DIST_W:0]       sum_ext;
    assign diff    = $signed({c_rd[knn_pkg::VAL_W-1], c_rd})
                   - $signed({q_rd[knn_pkg::VAL_W-1], q_rd});
    assign adiff   = diff[knn_pkg::VAL_W] ? (knn_pkg::VAL_W+1)'(-diff) : diff;
    assign sum_ext = {1'b0, r_sum} + (knn_pkg::DIST_W+1)'(r_sq);

    logic                       offer, bbusy;
    logic [knn_pkg::DIST_W-1:0] b_dist;
    logic [knn_pkg::LBL_W-1:0]  b_lbl;
    assign offer = (r_state == ST_OFF);

    knn_best u_best (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (accept && i_func == knn_pkg::FUNC_QUERY
                    && {1'b0, i_element_index} == len - 1'b1),
        .i_offer   (offer),
        .i_dist    (r_sum),
        .i_label   (knn_pkg::LBL_W'(r_cen) + 1'b1),
        .i_k       (kk),
        .i_rd_slot (r_slot[knn_pkg::K_W-1:0]),
        .o_rd_dist (b_dist),
        .o_rd_label(b_lbl),
        .o_busy    (bbusy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cen   <= '0;
            r_el    <= '0;
            r_rv    <= 1'b0;
            r_sqv   <= 1'b0;
            r_rcnt  <= '0;
            r_slot  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_rv    <= rd_go;
            r_sqv   <= r_rv;
            r_sq    <= adiff * adiff;
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_func == knn_pkg::FUNC_QUERY
                        && {1'b0, i_element_index} == len - 1'b1) begin
                        r_state <= ST_RUN;
                        r_cen   <= '0;
                        r_el    <= '0;
                        r_rcnt  <= '0;
                        r_sum   <= '0;
                    end
                end
                ST_RUN: begin
                    // issue reads; accumulate as squares land
                    if (rd_go) begin
                        r_el <= r_el + 1'b1;
                    end
                    if (r_sqv) begin
                        r_sum  <= sum_ext[knn_pkg::DIST_W] ? knn_pkg::DIST_ONES
                                : sum_ext[knn_pkg::DIST_W-1:0];
                        r_rcnt <= r_rcnt + 1'b1;
                        if (r_rcnt + 1'b1 == len) begin
                            r_state <= ST_OFF;
                        end
                    end
                end
                ST_OFF: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    // hold until the worst-slot rescan has settled
                    if (!bbusy) begin
                        if (r_cen + 1'b1 == nc) begin
                            r_state <= ST_EMIT;
                            r_slot  <= '0;
                        end else begin
                            r_cen   <= r_cen + 1'b1;
                            r_el    <= '0;
                            r_rcnt  <= '0;
                            r_sum   <= '0;
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_EMIT: begin
                    o_valid             <= 1'b1;
                    o_neighbor_label    <= b_lbl;
                    o_neighbor_distance <= b_dist;
                    o_last_neighbor     <= (r_slot + 1'b1 == kk);
                    r_slot              <= r_slot + 1'b1;
                    if (r_slot + 1'b1 == kk) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a search never accepts a new element
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept) else $error("accept while searching");
    // results only come out of the emit phase
    a_valid_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == ST_EMIT) else $error("stray result");
    // an offer is never made while the best list is rescanning
    a_offer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        offer |-> !bbusy) else $error("offer during rescan");
endmodule

// ===== tb/knn_center_search_test.sv =====
// Self-checking testbench for the k-nearest-neighbor center search block.
// Depends on knn_pkg and knn_center_search.
module knn_center_search_test;
    typedef struct packed {
        logic [knn_pkg::LBL_W-1:0]  label;
        logic [knn_pkg::DIST_W-1:0] distance;
        logic                       last;
    } t_neighbor;

    typedef struct packed {
        logic        func;
        logic [7:0]  cidx;
        logic [5:0]  eidx;
        logic [15:0] val;
        logic        typed;
    } t_elem_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_func = knn_pkg::FUNC_CENTER;
    logic [7:0]                     i_center_index = '0;
    logic [5:0]                     i_element_index = '0;
    logic signed [15:0]             i_element_value = '0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [knn_pkg::CFG_IDX_W-1:0]  i_cfg_index = knn_pkg::REG_VLEN;
    logic [knn_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_valid;
    logic [8:0]                     o_neighbor_label;
    logic [39:0]                    o_neighbor_distance;
    logic                           o_last_neighbor;

    knn_center_search DUT (.*);

    always #1 i_clk = ~i_clk;

    // Shadow copy of the block's stores and registers.
    logic [15:0] center_mem [knn_pkg::CENTERS_MAX][knn_pkg::DIM_MAX];
    bit          center_known [knn_pkg::CENTERS_MAX][knn_pkg::DIM_MAX];
    logic [15:0] query_mem [knn_pkg::DIM_MAX];
    int          vlen_reg = 64;
    int          ccnt_reg = 256;
    int          ncnt_reg = 8;

    t_neighbor   neighbors_due[$];   // expected neighbors, oldest first
    t_neighbor   search_out[$];      // neighbors found by the last search
    t_neighbor   typed_res[4];
    t_elem_row   directed[9];
    int          errors = 0;
    int          item_count = 0;
    bit          calm = 1'b0;         // no idle bursts near the end

    function automatic int clamp_reg(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1: return 16'($urandom_range(0, 4)) - 16'd2;   // invites ties
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Brute-force search over the shadow stores; fills search_out.
    task automatic run_search();
        int                         len, nc, k, ws, a, b, diff;
        logic [knn_pkg::DIST_W-1:0] bd [knn_pkg::K_MAX];
        logic [knn_pkg::LBL_W-1:0]  bl [knn_pkg::K_MAX];
        logic [knn_pkg::DIST_W-1:0] wd, mv;
        longint unsigned            sum;
        t_neighbor                  nb;
        len = clamp_reg(vlen_reg, knn_pkg::DIM_MAX);
        nc  = clamp_reg(ccnt_reg, knn_pkg::CENTERS_MAX);
        k   = clamp_reg(ncnt_reg, knn_pkg::K_MAX);
        for (int s = 0; s < knn_pkg::K_MAX; s++) begin
            bd[s] = knn_pkg::DIST_ONES;
            bl[s] = '0;
        end
        ws = 0;
        wd = knn_pkg::DIST_ONES;
        for (int c = 0; c < nc; c++) begin
            sum = 0;
            for (int e = 0; e < len; e++) begin
                a = $signed(center_mem[c][e]);
                b = $signed(query_mem[e]);
                diff = a - b;
                if (diff < 0) diff = -diff;
                sum += longint'(diff) * longint'(diff);
                if (sum > knn_pkg::DIST_ONES) sum = knn_pkg::DIST_ONES;
            end
            if (sum[knn_pkg::DIST_W-1:0] < wd) begin
                bd[ws] = sum[knn_pkg::DIST_W-1:0];
                bl[ws] = knn_pkg::LBL_W'(c + 1);
                // rescan for the worst slot; ties stay on the lowest slot
                mv = '0;
                ws = 0;
                for (int s = 0; s < k; s++) begin
                    if (bd[s] > mv) begin
                        mv = bd[s];
                        ws = s;
                    end
                end
                wd = mv;
            end
        end
        search_out.delete();
        for (int s = 0; s < k; s++) begin
            nb.label    = bl[s];
            nb.distance = bd[s];
            nb.last     = (s == k - 1);
            search_out.push_back(nb);
        end
    endtask

    // Present one element, hold it until the transfer, then update the shadow.
    task automatic send_element(logic f, logic [7:0] c, logic [5:0] e, logic [15:0] v,
                                bit typed);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_func          <= f;
        i_center_index  <= c;
        i_element_index <= e;
        i_element_value <= v;
        do @(posedge i_clk); while (busy);
        item_count++;
        if (f == knn_pkg::FUNC_CENTER) begin
            center_mem[c][e]   = v;
            center_known[c][e] = 1'b1;
        end else begin
            query_mem[e] = v;
            if (e == clamp_reg(vlen_reg, knn_pkg::DIM_MAX) - 1) begin
                run_search();
                if (typed) foreach (typed_res[i]) neighbors_due.push_back(typed_res[i]);
                else foreach (search_out[i]) neighbors_due.push_back(search_out[i]);
            end
        end
    endtask

    // Drain the block, then write all three registers back to back.
    task automatic write_regs(int v, int c, int k);
        int vals [3];
        vals = '{v, c, k};
        @(negedge i_clk) start <= 1'b0;
        while (neighbors_due.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        for (int i = 0; i < 3; i++) begin
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= knn_pkg::CFG_IDX_W'(i);
            i_cfg_data  <= knn_pkg::CFG_DATA_W'(vals[i]);
            do @(posedge i_clk); while (!o_cfg_ready);
            case (knn_pkg::CFG_IDX_W'(i))
                knn_pkg::REG_VLEN: vlen_reg = vals[i] & 'h7F;
                knn_pkg::REG_CCNT: ccnt_reg = vals[i] & 'h1FF;
                knn_pkg::REG_NCNT: ncnt_reg = vals[i] & 'hF;
                default: ;
            endcase
        end
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // One setting: fill every center element the search will read, then run queries
    // with random content, sprinkled with stray center writes and ignored-length elements.
    task automatic run_phase(int v, int c, int k, int queries);
        int len, nc, e;
        write_regs(v, c, k);
        len = clamp_reg(vlen_reg, knn_pkg::DIM_MAX);
        nc  = clamp_reg(ccnt_reg, knn_pkg::CENTERS_MAX);
        for (int ci = 0; ci < nc; ci++)
            for (int ei = 0; ei < len; ei++)
                if (!center_known[ci][ei])
                    send_element(knn_pkg::FUNC_CENTER, 8'(ci), 6'(ei), pick_value(), 1'b0);
        repeat (queries) begin
            for (int ei = 0; ei < len - 1; ei++) begin
                if ($urandom_range(0, 4) == 0) begin
                    if (len < knn_pkg::DIM_MAX && $urandom_range(0, 1)) begin
                        e = $urandom_range(len, knn_pkg::DIM_MAX - 1);
                        send_element(knn_pkg::FUNC_QUERY, 8'($urandom), 6'(e),
                                     pick_value(), 1'b0);
                    end else begin
                        send_element(knn_pkg::FUNC_CENTER, 8'($urandom), 6'($urandom),
                                     pick_value(), 1'b0);
                    end
                end
                send_element(knn_pkg::FUNC_QUERY, 8'($urandom), 6'(ei), pick_value(), 1'b0);
            end
            send_element(knn_pkg::FUNC_QUERY, 8'($urandom), 6'(len - 1), pick_value(), 1'b0);
        end
    endtask

    // Check each strobed neighbor against the oldest expectation.
    always @(posedge i_clk) begin
        t_neighbor want;
        if (i_rst_n && o_valid) begin
            if (neighbors_due.size() == 0) begin
                report_mismatch("unexpected neighbor label", o_neighbor_label, 0);
            end else begin
                want = neighbors_due.pop_front();
                if (o_neighbor_label !== want.label)
                    report_mismatch("neighbor_label", o_neighbor_label, want.label);
                if (o_neighbor_distance !== want.distance)
                    report_mismatch("neighbor_distance", o_neighbor_distance, want.distance);
                if (o_last_neighbor !== want.last)
                    report_mismatch("last_neighbor", o_last_neighbor, want.last);
            end
        end
    end

    initial begin
        // Directed rows under vector_length 1, two centers, four slots:
        // full-scale spread, an exact match, unfilled slots, a query element past
        // the length, a tie between identical centers, and the extreme indexes.
        directed = '{
            '{knn_pkg::FUNC_CENTER, 8'd0,   6'd0,  16'h7FFF, 1'b0},
            '{knn_pkg::FUNC_CENTER, 8'd1,   6'd0,  16'h8000, 1'b0},
            '{knn_pkg::FUNC_QUERY,  8'd0,   6'd0,  16'h8000, 1'b1},
            '{knn_pkg::FUNC_QUERY,  8'hFF,  6'd5,  16'h1234, 1'b0},
            '{knn_pkg::FUNC_QUERY,  8'd0,   6'd0,  16'h7FFF, 1'b0},
            '{knn_pkg::FUNC_CENTER, 8'd1,   6'd0,  16'h7FFF, 1'b0},
            '{knn_pkg::FUNC_QUERY,  8'd0,   6'd0,  16'h0000, 1'b0},
            '{knn_pkg::FUNC_CENTER, 8'd255, 6'd63, 16'hA5A5, 1'b0},
            '{knn_pkg::FUNC_QUERY,  8'd0,   6'd63, 16'h5A5A, 1'b0}
        };
        // Center 1 matches exactly, center 0 sits at full scale; two slots stay empty.
        typed_res = '{
            '{9'd1, 40'd4294836225,     1'b0},
            '{9'd2, 40'd0,              1'b0},
            '{9'd0, knn_pkg::DIST_ONES, 1'b0},
            '{9'd0, knn_pkg::DIST_ONES, 1'b1}
        };
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        write_regs(1, 2, 4);
        foreach (directed[i])
            send_element(directed[i].func, directed[i].cidx, directed[i].eidx,
                         directed[i].val, directed[i].typed);

        // Extremes: every center with zero length and count registers, then the longest vectors
        // with register values past range.
        run_phase(0, 511, 0, 2);
        run_phase(127, 1, 15, 1);

        while (item_count < 420) begin
            run_phase(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                      $urandom_range(0, 10), $urandom_range(2, 4));
        end
        calm = 1'b1;
        while (item_count < 460) begin
            run_phase(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                      $urandom_range(0, 10), $urandom_range(2, 4));
        end

        @(negedge i_clk) start <= 1'b0;
        while (neighbors_due.size() != 0 || busy) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== knn_center_search.f =====
sv/knn_pkg.sv
sv/knn_ram.sv
sv/knn_best.sv
sv/knn_center_search.sv
tb/knn_center_search_test.sv
